// ===== hdl/kct_pkg.sv =====
package kct_pkg;

  localparam int unsigned TableCapacity = 8;
  localparam int unsigned CountWidth    = 4;

  typedef enum logic {
    ReqUpsert = 1'b0,
    ReqRemove = 1'b1
  } req_type_e;

  typedef enum logic {
    StatusOk   = 1'b0,
    StatusFull = 1'b1
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [11:0] conn_handle;
    logic [5:0]  chan_num;
    logic        dir_bit;
    logic [15:0] local_id;
    logic [15:0] remote_id;
    logic        initiator;
    logic [15:0] send_credits;
    logic [15:0] recv_credits;
    logic [15:0] recv_total;
    logic [15:0] frame_limit;
  } req_t;

  typedef struct packed {
    status_e               status_code;
    logic                  incomplete;
    logic [CountWidth-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [11:0] conn_handle;
    logic [5:0]  chan_num;
    logic        dir_bit;
  } key_t;

  typedef struct packed {
    logic [15:0] local_id;
    logic [15:0] remote_id;
    logic        initiator;
    logic [15:0] send_credits;
    logic [15:0] recv_credits;
    logic [15:0] recv_total;
    logic [15:0] frame_limit;
  } payload_t;

  typedef struct packed {
    key_t     key;
    payload_t pay;
  } rec_t;

  // Per-cell control from the table controller.
  typedef struct packed {
    logic occupied;  // an item is in process and the cell index is below the entry count
    logic tail;      // cell index equals the entry count
    logic append;    // the current upsert missed and the table has room
  } cell_ctl_t;

endpackage

// ===== hdl/kct_cell.sv =====
module kct_cell (
  input  logic                clk_i,
  input  kct_pkg::req_t       req_i,
  input  kct_pkg::cell_ctl_t  ctl_i,
  input  logic                hit_before_i,
  input  kct_pkg::rec_t       next_rec_i,
  output logic                hit_o,
  output kct_pkg::rec_t       rec_o
);

  kct_pkg::rec_t rec_q, rec_d;
  kct_pkg::key_t req_key;
  kct_pkg::payload_t req_pay;
  logic match, first;

  assign req_key = '{conn_handle: req_i.conn_handle,
                     chan_num:    req_i.chan_num,
                     dir_bit:     req_i.dir_bit};
  assign req_pay = '{local_id:     req_i.local_id,
                     remote_id:    req_i.remote_id,
                     initiator:    req_i.initiator,
                     send_credits: req_i.send_credits,
                     recv_credits: req_i.recv_credits,
                     recv_total:   req_i.recv_total,
                     frame_limit:  req_i.frame_limit};

  assign match = ctl_i.occupied && (rec_q.key == req_key);
  assign first = match && !hit_before_i;
  assign hit_o = hit_before_i || match;

  always_comb begin
    rec_d = rec_q;
    if (req_i.req_type == kct_pkg::ReqRemove) begin
      // Every cell from the first match upward takes its upper neighbor's record.
      if (hit_o) begin
        rec_d = next_rec_i;
      end
    end else if (first) begin
      rec_d.pay = req_pay;
    end else if (ctl_i.append && ctl_i.tail) begin
      rec_d.key = req_key;
      rec_d.pay = req_pay;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== hdl/keyed_channel_table_upsert_remove.sv =====
// Channel   Ports                      Direction  Handshake
// request   start_i, busy_o, req_i     in         taken when start_i && !busy_o
// result    done_o, rsp_o              out        valid for the one cycle done_o is high
//
// An item is registered at acceptance and processed by the cell row in the next
// cycle, so busy_o is high for that cycle and no new item is taken meanwhile.
// The result word appears on rsp_o in the cycle after processing, with done_o.
// Reset clears the entry count, the incomplete flag and the pipeline strobes;
// the record cells are not reset. The receiver cannot stall the result.
module keyed_channel_table_upsert_remove #(
  parameter int unsigned TableCapacity = kct_pkg::TableCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  kct_pkg::req_t req_i,
  output logic          done_o,
  output kct_pkg::rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(TableCapacity + 1);
  localparam int unsigned CountWidth = kct_pkg::CountWidth;

  kct_pkg::req_t     req_q;
  logic              valid_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              flag_q, flag_d;
  logic              done_q;
  kct_pkg::rsp_t     rsp_q;

  kct_pkg::cell_ctl_t ctl   [TableCapacity];
  kct_pkg::rec_t      rec   [TableCapacity];
  logic [TableCapacity:0] hit_chain;

  logic is_remove, hit, full, append;
  logic [CntW+CountWidth-1:0] count_ext;

  assign busy_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i && !valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !valid_q) begin
      req_q <= req_i;
    end
  end

  assign is_remove = (req_q.req_type == kct_pkg::ReqRemove);
  assign hit       = hit_chain[TableCapacity];
  assign full      = (count_q == CntW'(TableCapacity));
  assign append    = valid_q && !is_remove && !hit && !full;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < TableCapacity; i++) begin : g_cell
    assign ctl[i].occupied = valid_q && (CntW'(i) < count_q);
    assign ctl[i].tail     = (CntW'(i) == count_q);
    assign ctl[i].append   = append;

    kct_cell u_cell (
      .clk_i        (clk_i),
      .req_i        (req_q),
      .ctl_i        (ctl[i]),
      .hit_before_i (hit_chain[i]),
      .next_rec_i   (rec[(i + 1 < TableCapacity) ? i + 1 : i]),
      .hit_o        (hit_chain[i+1]),
      .rec_o        (rec[i])
    );
  end

  always_comb begin
    count_d = count_q;
    flag_d  = flag_q;
    if (valid_q) begin
      if (is_remove) begin
        if (hit) begin
          count_d = count_q - CntW'(1);
        end
      end else if (!hit) begin
        if (full) begin
          flag_d = 1'b1;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  assign count_ext = (CntW + CountWidth)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flag_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      flag_q  <= flag_d;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q.status_code <= (!is_remove && !hit && full) ? kct_pkg::StatusFull
                                                        : kct_pkg::StatusOk;
      rsp_q.incomplete  <= flag_d;
      rsp_q.entry_count <= count_ext[CountWidth-1:0];
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableCapacity))
    else $error("entry count above capacity");

  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("item accepted while busy");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(valid_q))
    else $error("result without a processed item");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |=> flag_q)
    else $error("incomplete flag cleared");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.status_code == kct_pkg::StatusFull) |->
      (count_q == CntW'(TableCapacity) && flag_q))
    else $error("refused insert with room left");
`endif

endmodule

// ===== bench/keyed_channel_table_upsert_remove_tb.sv =====
module keyed_channel_table_upsert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {PayZero, PayOnes, PayRandom} pay_fill_e;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  kct_pkg::req_t  req_i;
  logic           done_o;
  kct_pkg::rsp_t  rsp_o;

  keyed_channel_table_upsert_remove dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Shadow of the channel table. Payload never reaches the result word, so only
  // the keys, the record count and the sticky flag are tracked.
  kct_pkg::key_t tbl_keys[kct_pkg::TableCapacity];
  int unsigned   tbl_count;
  logic          tbl_incomplete;

  kct_pkg::rsp_t owed_rsps[$];
  kct_pkg::rsp_t due_rsp;
  int unsigned   fail_count;
  bit            steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic kct_pkg::rsp_t update_table(kct_pkg::req_t r);
    kct_pkg::key_t k;
    int            hit;
    kct_pkg::rsp_t o;
    k.conn_handle = r.conn_handle;
    k.chan_num    = r.chan_num;
    k.dir_bit     = r.dir_bit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_keys[i] == k) hit = i;
    end
    o.status_code = kct_pkg::StatusOk;
    if (r.req_type == kct_pkg::ReqUpsert) begin
      if (hit < 0) begin
        if (tbl_count >= kct_pkg::TableCapacity) begin
          tbl_incomplete = 1'b1;
          o.status_code  = kct_pkg::StatusFull;
        end else begin
          tbl_keys[tbl_count] = k;
          tbl_count++;
        end
      end
    end else if (hit >= 0) begin
      // Later records move down one slot so insertion order is kept.
      for (int i = hit; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i + 1];
      tbl_count--;
    end
    o.incomplete  = tbl_incomplete;
    o.entry_count = tbl_count[kct_pkg::CountWidth-1:0];
    return o;
  endfunction

  function automatic kct_pkg::key_t random_key();
    kct_pkg::key_t k;
    k.conn_handle = 12'($urandom);
    k.chan_num    = 6'($urandom);
    k.dir_bit     = 1'($urandom_range(1));
    return k;
  endfunction

  function automatic kct_pkg::req_t make_req(kct_pkg::req_type_e op, kct_pkg::key_t k,
                                             pay_fill_e fill);
    kct_pkg::req_t r;
    r.req_type    = op;
    r.conn_handle = k.conn_handle;
    r.chan_num    = k.chan_num;
    r.dir_bit     = k.dir_bit;
    if (fill == PayRandom) begin
      r.local_id     = 16'($urandom);
      r.remote_id    = 16'($urandom);
      r.initiator    = 1'($urandom_range(1));
      r.send_credits = 16'($urandom);
      r.recv_credits = 16'($urandom);
      r.recv_total   = 16'($urandom);
      r.frame_limit  = 16'($urandom);
    end else begin
      r.local_id     = {16{fill == PayOnes}};
      r.remote_id    = {16{fill == PayOnes}};
      r.initiator    = (fill == PayOnes);
      r.send_credits = {16{fill == PayOnes}};
      r.recv_credits = {16{fill == PayOnes}};
      r.recv_total   = {16{fill == PayOnes}};
      r.frame_limit  = {16{fill == PayOnes}};
    end
    return r;
  endfunction

  // Called at a falling edge; start_i stays high unless an idle gap is taken.
  task automatic maybe_pause();
    if (!steady && $urandom_range(99) < 33) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_word(kct_pkg::req_t r);
    kct_pkg::rsp_t exp_rsp;
    maybe_pause();
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    exp_rsp   = update_table(r);
    owed_rsps = {owed_rsps, exp_rsp};
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (owed_rsps.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Eight distinct keys fill the table, including keys that differ only in
  // direction or channel; a ninth key is then refused while a hit still lands.
  task automatic test_fill_and_overflow(ref kct_pkg::key_t keys[8]);
    keys[0] = kct_pkg::key_t'{12'h000, 6'h00, 1'b0};
    keys[1] = kct_pkg::key_t'{12'hFFF, 6'h3F, 1'b1};
    keys[2] = kct_pkg::key_t'{12'hFFF, 6'h3F, 1'b0};
    keys[3] = kct_pkg::key_t'{12'hFFF, 6'h3E, 1'b1};
    keys[4] = kct_pkg::key_t'{12'h000, 6'h00, 1'b1};
    keys[5] = kct_pkg::key_t'{12'h5A5, 6'h2A, 1'b0};
    keys[6] = kct_pkg::key_t'{12'hA5A, 6'h15, 1'b1};
    keys[7] = kct_pkg::key_t'{12'h001, 6'h01, 1'b0};
    for (int i = 0; i < 8; i++) begin
      send_word(make_req(kct_pkg::ReqUpsert, keys[i], (i % 2) ? PayOnes : PayZero));
    end
    send_word(make_req(kct_pkg::ReqUpsert, kct_pkg::key_t'{12'h800, 6'h20, 1'b0},
                       PayOnes));
    send_word(make_req(kct_pkg::ReqUpsert, keys[3], PayRandom));
    send_word(make_req(kct_pkg::ReqUpsert, keys[7], PayZero));
  endtask

  task automatic test_remove_cases(ref kct_pkg::key_t keys[8]);
    send_word(make_req(kct_pkg::ReqRemove, keys[0], PayOnes));
    send_word(make_req(kct_pkg::ReqRemove, keys[0], PayRandom));
    send_word(make_req(kct_pkg::ReqRemove, keys[5], PayZero));
    send_word(make_req(kct_pkg::ReqRemove, keys[7], PayOnes));
    send_word(make_req(kct_pkg::ReqUpsert, kct_pkg::key_t'{12'h800, 6'h20, 1'b0},
                       PayRandom));
    send_word(make_req(kct_pkg::ReqUpsert, keys[0], PayOnes));
    send_word(make_req(kct_pkg::ReqRemove, kct_pkg::key_t'{12'h123, 6'h3F, 1'b1},
                       PayRandom));
  endtask

  // The sender holds off until the table has answered everything, then resumes.
  task automatic test_drain_and_resume(ref kct_pkg::key_t keys[8]);
    drain_results();
    send_word(make_req(kct_pkg::ReqUpsert, keys[2], PayOnes));
    send_word(make_req(kct_pkg::ReqRemove, keys[1], PayZero));
  endtask

  // Phases of mostly inserts, mixed traffic or mostly removes over a small key pool keep the
  // table cycling between empty, partly filled and full.
  task automatic test_random_traffic(int unsigned n_items);
    kct_pkg::key_t      pool[12];
    int unsigned        sent;
    int unsigned        phase_len;
    int unsigned        upsert_pct;
    kct_pkg::key_t      k;
    kct_pkg::req_type_e op;
    sent = 0;
    while (sent < n_items) begin
      for (int i = 0; i < 12; i++) begin
        pool[i] = random_key();
        if (i > 0 && $urandom_range(3) == 0) begin
          pool[i] = pool[i - 1];
          pool[i].dir_bit = ~pool[i - 1].dir_bit;
        end
      end
      phase_len = $urandom_range(30, 80);
      case ($urandom_range(2))
        0: begin
          upsert_pct = 80;
        end
        1: begin
          upsert_pct = 50;
        end
        default: begin
          upsert_pct = 25;
        end
      endcase
      for (int j = 0; j < phase_len && sent < n_items; j++) begin
        steady = (sent >= 400 && sent < 600);
        k  = ($urandom_range(19) == 0) ? random_key() : pool[$urandom_range(11)];
        op = ($urandom_range(99) < upsert_pct) ? kct_pkg::ReqUpsert : kct_pkg::ReqRemove;
        send_word(make_req(op, k, PayRandom));
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (owed_rsps.size() == 0) begin
        $error("result word with no outstanding request: %p", rsp_o);
        fail_count++;
      end else begin
        due_rsp = owed_rsps.pop_front();
        if (rsp_o.status_code !== due_rsp.status_code) begin
          $error("status_code: expected %0d, got %0d", due_rsp.status_code, rsp_o.status_code);
          fail_count++;
        end
        if (rsp_o.incomplete !== due_rsp.incomplete) begin
          $error("incomplete: expected %0d, got %0d", due_rsp.incomplete, rsp_o.incomplete);
          fail_count++;
        end
        if (rsp_o.entry_count !== due_rsp.entry_count) begin
          $error("entry_count: expected %0d, got %0d", due_rsp.entry_count, rsp_o.entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    kct_pkg::key_t keys[8];
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    req_i          <= '0;
    tbl_count      = 0;
    tbl_incomplete = 1'b0;
    fail_count     = 0;
    steady         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_fill_and_overflow(keys);
    test_remove_cases(keys);
    test_drain_and_resume(keys);
    test_random_traffic(1100);

    start_i <= 1'b0;
    while (owed_rsps.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (owed_rsps.size() != 0) begin
      $error("%0d result words never arrived", owed_rsps.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
